/* design/rcd_pkg.sv */
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the chunk stream deframer.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int STREAM_SLOTS = 8;
  localparam int SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [23:0] TS_EXTENDED = 24'hFFFFFF;
  localparam logic [16:0] CS_OFFSET = 17'd64;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_TABLE_FULL = 2'd2;
  localparam logic [1:0] KIND_NO_HEADER = 2'd3;

  localparam logic [7:0] MSG_SET_CHUNK = 8'd1;
  localparam logic [7:0] MSG_ABORT = 8'd2;
  localparam logic [7:0] MSG_WINDOW = 8'd5;

  localparam logic REG_CHUNK_SIZE = 1'b0;
  localparam logic REG_WINDOW_SIZE = 1'b1;

  localparam logic [30:0] RESET_CHUNK_SIZE = 31'd128;
  localparam logic [31:0] RESET_WINDOW_SIZE = 32'd2500000;

  typedef enum logic [3:0] {
    PH_BASIC,
    PH_CS1,
    PH_CS2,
    PH_TS,
    PH_LEN,
    PH_TYPE,
    PH_MSID,
    PH_EXT,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [16:0] tag;
    logic [31:0] time_abs;
    logic [23:0] length;
    logic [7:0]  type_id;
    logic [31:0] msg_stream;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [16:0] chunk_stream;
    logic [7:0]  msg_type;
    logic [31:0] msg_stream;
    logic [31:0] msg_time;
    logic [23:0] msg_length;
    logic        last_of_message;
    logic        ack_needed;
    logic [31:0] ack_count;
  } result_t;

endpackage

/* design/rcd_front.sv */
// ----------------------------------------------------------------------------
// rcd_front
// Byte parser: header decode, chunk stream table, control messages and
// received byte accounting; emits at most one result per byte.
// ----------------------------------------------------------------------------
module rcd_front import rcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_take,
  input  logic [7:0]  in_byte,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic [2:0]  fbc, fbc_next;
  logic [1:0]  fmt, fmt_next;
  logic [16:0] sid, sid_next;
  logic [31:0] tm, tm_next;
  logic [23:0] len, len_next;
  logic [7:0]  typ, typ_next;
  logic [31:0] msid, msid_next;
  logic [23:0] cleft, cleft_next;
  logic [30:0] csize, csize_next;
  logic [31:0] wsize, wsize_next;
  logic [31:0] rcnt, rcnt_next;
  logic [31:0] cval, cval_next;
  logic [SLOT_W-1:0] cslot, cslot_next;

  logic [STREAM_SLOTS-1:0] valid, valid_next;
  slot_t       slots [STREAM_SLOTS];
  logic [23:0] acc [STREAM_SLOTS];

  logic              slot_we;
  slot_t             slot_wdata;
  logic              acc_we;
  logic [23:0]       acc_wdata;

  logic              do_begin, do_finish, put_en, put_last, put_end;
  logic [1:0]        put_kind;
  logic [7:0]        put_byte;
  logic              hit, free_hit;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic [23:0]       acc_cur, rem, acc_inc;
  logic [30:0]       eff;
  logic              is_last, ack;
  slot_t             rd;

  always_comb begin
    phase_next = phase;
    fbc_next = fbc;
    fmt_next = fmt;
    sid_next = sid;
    tm_next = tm;
    len_next = len;
    typ_next = typ;
    msid_next = msid;
    cleft_next = cleft;
    csize_next = csize;
    wsize_next = wsize;
    rcnt_next = rcnt;
    cval_next = cval;
    cslot_next = cslot;
    valid_next = valid;
    slot_we = 1'b0;
    slot_wdata = '0;
    acc_we = 1'b0;
    acc_wdata = '0;
    do_begin = 1'b0;
    do_finish = 1'b0;
    put_en = 1'b0;
    put_kind = KIND_PAYLOAD;
    put_byte = '0;
    put_last = 1'b0;
    put_end = 1'b0;
    hit = 1'b0;
    free_hit = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    acc_cur = '0;
    rem = '0;
    acc_inc = '0;
    eff = '0;
    is_last = 1'b0;
    ack = 1'b0;
    rd = '0;
    res = '0;

    if (cfg_write) begin
      if (cfg_index == REG_CHUNK_SIZE) begin
        csize_next = cfg_data[30:0];
      end else begin
        wsize_next = cfg_data;
      end
    end

    if (in_take) begin
      rcnt_next = rcnt + 32'd1;
      case (phase)
        PH_BASIC: begin
          fmt_next = in_byte[7:6];
          sid_next = {11'd0, in_byte[5:0]};
          if (in_byte[5:0] == 6'd0) begin
            phase_next = PH_CS1;
          end else if (in_byte[5:0] == 6'd1) begin
            fbc_next = '0;
            sid_next = '0;
            phase_next = PH_CS2;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_CS1: begin
          sid_next = {9'd0, in_byte} + CS_OFFSET;
          do_begin = 1'b1;
        end
        PH_CS2: begin
          if (fbc == 3'd0) begin
            sid_next = {9'd0, in_byte};
            fbc_next = 3'd1;
          end else begin
            sid_next = sid + {1'b0, in_byte, 8'd0} + CS_OFFSET;
            do_begin = 1'b1;
          end
        end
        PH_TS: begin
          tm_next = {tm[23:0], in_byte};
          fbc_next = fbc + 3'd1;
          if (fbc_next == 3'd3) begin
            fbc_next = '0;
            if (fmt == 2'd2) begin
              if (tm_next == {8'd0, TS_EXTENDED}) begin
                tm_next = '0;
                phase_next = PH_EXT;
              end else begin
                do_finish = 1'b1;
              end
            end else begin
              phase_next = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          len_next = {len[15:0], in_byte};
          fbc_next = fbc + 3'd1;
          if (fbc_next == 3'd3) begin
            fbc_next = '0;
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          typ_next = in_byte;
          if (fmt == 2'd0) begin
            phase_next = PH_MSID;
          end else if (tm == {8'd0, TS_EXTENDED}) begin
            tm_next = '0;
            phase_next = PH_EXT;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_MSID: begin
          msid_next = msid | ({24'd0, in_byte} << {fbc[1:0], 3'd0});
          fbc_next = fbc + 3'd1;
          if (fbc_next == 3'd4) begin
            fbc_next = '0;
            if (tm == {8'd0, TS_EXTENDED}) begin
              tm_next = '0;
              phase_next = PH_EXT;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
        PH_EXT: begin
          tm_next = {tm[23:0], in_byte};
          fbc_next = fbc + 3'd1;
          if (fbc_next == 3'd4) begin
            fbc_next = '0;
            do_finish = 1'b1;
          end
        end
        PH_DATA: begin
          acc_cur = acc[cslot];
          if (acc_cur < 24'd4) begin
            cval_next = {cval[23:0], in_byte};
          end
          acc_inc = acc_cur + 24'd1;
          cleft_next = cleft - 24'd1;
          is_last = acc_inc >= len;
          acc_we = 1'b1;
          acc_wdata = is_last ? 24'd0 : acc_inc;
          if (is_last && len >= 24'd4) begin
            if (typ == MSG_SET_CHUNK) begin
              csize_next = cval_next[30:0];
            end else if (typ == MSG_WINDOW) begin
              wsize_next = cval_next;
            end else if (typ == MSG_ABORT) begin
              for (int i = 0; i < STREAM_SLOTS; i++) begin
                if (valid[i] && {15'd0, slots[i].tag} == cval_next) begin
                  valid_next[i] = 1'b0;
                end
              end
            end
          end
          if (cleft_next == 24'd0) begin
            phase_next = PH_BASIC;
          end
          put_en = 1'b1;
          put_kind = KIND_PAYLOAD;
          put_byte = in_byte;
          put_last = is_last;
          put_end = cleft_next == 24'd0;
        end
        default: begin
          phase_next = PH_BASIC;
        end
      endcase

      if (do_begin) begin
        for (int i = STREAM_SLOTS - 1; i >= 0; i--) begin
          if (valid[i]) begin
            if (slots[i].tag == sid_next) begin
              hit = 1'b1;
              hit_idx = SLOT_W'(i);
            end
          end else begin
            free_hit = 1'b1;
            free_idx = SLOT_W'(i);
          end
        end
        if (!hit && fmt_next != 2'd0) begin
          phase_next = PH_BASIC;
          put_en = 1'b1;
          put_kind = KIND_NO_HEADER;
        end else if (!hit && !free_hit) begin
          phase_next = PH_BASIC;
          put_en = 1'b1;
          put_kind = KIND_TABLE_FULL;
        end else begin
          cslot_next = hit ? hit_idx : free_idx;
          tm_next = '0;
          fbc_next = '0;
          if (fmt_next == 2'd3) begin
            do_finish = 1'b1;
          end else begin
            if (fmt_next == 2'd0) begin
              len_next = '0;
              typ_next = '0;
              msid_next = '0;
            end else if (fmt_next == 2'd1) begin
              len_next = '0;
              typ_next = '0;
            end
            phase_next = PH_TS;
          end
        end
      end

      if (do_finish) begin
        rd = slots[cslot_next];
        acc_cur = '0;
        if (fmt_next == 2'd3) begin
          tm_next = rd.time_abs;
          len_next = rd.length;
          typ_next = rd.type_id;
          msid_next = rd.msg_stream;
          acc_cur = acc[cslot_next];
        end else if (fmt_next != 2'd0) begin
          tm_next = tm_next + rd.time_abs;
          msid_next = rd.msg_stream;
          if (fmt_next == 2'd2) begin
            len_next = rd.length;
            typ_next = rd.type_id;
          end
        end
        valid_next[cslot_next] = 1'b1;
        slot_we = 1'b1;
        slot_wdata = '{tag: sid_next, time_abs: tm_next, length: len_next,
                       type_id: typ_next, msg_stream: msid_next};
        rem = (acc_cur < len_next) ? (len_next - acc_cur) : 24'd0;
        eff = (csize_next == 31'd0) ? 31'd1 : csize_next;
        cleft_next = ({7'd0, rem} < eff) ? rem : eff[23:0];
        acc_we = 1'b1;
        acc_wdata = acc_cur;
        if (cleft_next == 24'd0) begin
          acc_wdata = '0;
          phase_next = PH_BASIC;
          put_en = 1'b1;
          put_kind = KIND_EMPTY;
          put_last = 1'b1;
          put_end = 1'b1;
        end else begin
          if (acc_cur == 24'd0) begin
            cval_next = '0;
          end
          phase_next = PH_DATA;
        end
      end

      if (put_en) begin
        ack = put_end && (rcnt_next > wsize_next);
        res.kind = put_kind;
        res.payload_byte = put_byte;
        res.chunk_stream = sid_next;
        if (put_kind != KIND_TABLE_FULL && put_kind != KIND_NO_HEADER) begin
          res.msg_type = typ_next;
          res.msg_stream = msid_next;
          res.msg_time = tm_next;
          res.msg_length = len_next;
        end
        res.last_of_message = put_last;
        res.ack_needed = ack;
        res.ack_count = ack ? rcnt_next : 32'd0;
        if (ack) begin
          rcnt_next = '0;
        end
      end
    end
  end

  assign res_valid = in_take && put_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BASIC;
      fbc <= '0;
      fmt <= '0;
      sid <= '0;
      tm <= '0;
      len <= '0;
      typ <= '0;
      msid <= '0;
      cleft <= '0;
      csize <= RESET_CHUNK_SIZE;
      wsize <= RESET_WINDOW_SIZE;
      rcnt <= '0;
      cval <= '0;
      cslot <= '0;
      valid <= '0;
    end else begin
      phase <= phase_next;
      fbc <= fbc_next;
      fmt <= fmt_next;
      sid <= sid_next;
      tm <= tm_next;
      len <= len_next;
      typ <= typ_next;
      msid <= msid_next;
      cleft <= cleft_next;
      csize <= csize_next;
      wsize <= wsize_next;
      rcnt <= rcnt_next;
      cval <= cval_next;
      cslot <= cslot_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slots[cslot_next] <= slot_wdata;
    end
    if (acc_we) begin
      acc[cslot_next] <= acc_wdata;
    end
  end

endmodule

/* design/rcd_queue.sv */
// ----------------------------------------------------------------------------
// rcd_queue
// Result queue between the parser and the consumer; the head entry drives
// the result ports.
// ----------------------------------------------------------------------------
module rcd_queue import rcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    empty
);

  result_t             entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr, do_rd;

  assign full = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/rtmp_chunk_deframer.sv */
// ----------------------------------------------------------------------------
// rtmp_chunk_deframer
// Chunk stream deframer: received bytes in, at most one tagged result per byte out.
// ----------------------------------------------------------------------------
// Input side is a push interface: drive in_byte and push; a byte transfers on a
// clock edge with push high and full low. Every byte is parsed in the cycle it
// transfers, so a byte can transfer in every cycle while full is low.
// Result side is a queue: while empty is low the oldest result is on the
// result ports; it transfers on an edge with pop high. A result is queued on
// the edge its byte transfers and shows once all older results are popped.
// Header bytes give no result, except error and empty-message results.
// The parser and the consumer are parted by a four-entry result queue; full
// rises only when that queue holds four results, so a stalled consumer
// stops input after four pending results and nothing is lost.
// Configuration writes (cfg_write, cfg_index, cfg_data) load the live chunk
// size or window size; the user must make them while the block is idle, as
// the block does not enforce it. Reset (rst, synchronous) empties the queue,
// clears the stream table and returns the chunk size to 128, window 2500000.
// ----------------------------------------------------------------------------
module rtmp_chunk_deframer import rcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [16:0] chunk_stream,
  output logic [7:0]  msg_type,
  output logic [31:0] msg_stream,
  output logic [31:0] msg_time,
  output logic [23:0] msg_length,
  output logic        last_of_message,
  output logic        ack_needed,
  output logic [31:0] ack_count
);

  logic    take;
  logic    res_valid;
  result_t res, head;

  assign take = push && !full;

  rcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_take   (take),
    .in_byte   (in_byte),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  rcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign kind = head.kind;
  assign payload_byte = head.payload_byte;
  assign chunk_stream = head.chunk_stream;
  assign msg_type = head.msg_type;
  assign msg_stream = head.msg_stream;
  assign msg_time = head.msg_time;
  assign msg_length = head.msg_length;
  assign last_of_message = head.last_of_message;
  assign ack_needed = head.ack_needed;
  assign ack_count = head.ack_count;

endmodule

/* design/rcd_checker.sv */
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks of the deframer's result channel.
// ----------------------------------------------------------------------------
module rcd_checker import rcd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [7:0]  payload_byte,
  input logic [7:0]  msg_type,
  input logic [31:0] msg_stream,
  input logic [31:0] msg_time,
  input logic [23:0] msg_length,
  input logic        last_of_message,
  input logic        ack_needed,
  input logic [31:0] ack_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(payload_byte)))
    else $error("result changed while waiting");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_TABLE_FULL || kind == KIND_NO_HEADER)) |->
    (msg_type == 8'd0 && msg_stream == 32'd0 && msg_time == 32'd0 &&
     msg_length == 24'd0 && !last_of_message))
    else $error("error result carries header fields");

  a_ack_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && !ack_needed) |-> (ack_count == 32'd0))
    else $error("ack count without ack request");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != KIND_PAYLOAD) |-> (payload_byte == 8'd0))
    else $error("payload byte on non-payload result");

endmodule

bind rtmp_chunk_deframer rcd_checker u_rcd_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .kind            (kind),
  .payload_byte    (payload_byte),
  .msg_type        (msg_type),
  .msg_stream      (msg_stream),
  .msg_time        (msg_time),
  .msg_length      (msg_length),
  .last_of_message (last_of_message),
  .ack_needed      (ack_needed),
  .ack_count       (ack_count)
);

/* tb/tb_rtmp_chunk_deframer.sv */
// ----------------------------------------------------------------------------
// tb_rtmp_chunk_deframer
// Self-checking bench for the chunk stream deframer. A generator builds
// mostly well-formed chunk streams (all cs_id forms, fmt 0 to 3, extended
// timestamps, split chunks, control messages, truncated messages, table full
// and missing header errors). Each transferred byte runs through a predictor
// of the parser and every popped result is compared with the oldest
// prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rtmp_chunk_deframer import rcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte = '0;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_CHUNK_SIZE;
  logic [31:0] cfg_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [16:0] chunk_stream;
  logic [7:0]  msg_type;
  logic [31:0] msg_stream;
  logic [31:0] msg_time;
  logic [23:0] msg_length;
  logic        last_of_message;
  logic        ack_needed;
  logic [31:0] ack_count;

  rtmp_chunk_deframer u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state as seen by the predictor
  phase_t      p_phase;
  bit [31:0]   p_cnt, p_fmt, p_cs, p_time, p_len, p_type, p_msid;
  bit [31:0]   p_left, p_chunk, p_window, p_rcvd, p_ctl, p_slot;
  bit          sv_valid [STREAM_SLOTS];
  bit [31:0]   sv_tag [STREAM_SLOTS];
  bit [31:0]   sv_time [STREAM_SLOTS];
  bit [31:0]   sv_len [STREAM_SLOTS];
  bit [31:0]   sv_type [STREAM_SLOTS];
  bit [31:0]   sv_msid [STREAM_SLOTS];
  bit [31:0]   sv_acc [STREAM_SLOTS];

  result_t     due_results[$];
  bit [7:0]    rx_stream[$];
  int          errors = 0;

  function automatic void parser_reset();
    p_phase = PH_BASIC;
    {p_cnt, p_fmt, p_cs, p_time, p_len, p_type, p_msid} = '0;
    {p_left, p_rcvd, p_ctl, p_slot} = '0;
    p_chunk = RESET_CHUNK_SIZE;
    p_window = RESET_WINDOW_SIZE;
    for (int i = 0; i < STREAM_SLOTS; i++) sv_valid[i] = 1'b0;
  endfunction

  function automatic void emit(bit [1:0] k, bit [7:0] b, bit last, bit cend);
    result_t r;
    r = '0;
    r.kind = k;
    r.payload_byte = b;
    r.chunk_stream = p_cs[16:0];
    if (k != KIND_TABLE_FULL && k != KIND_NO_HEADER) begin
      r.msg_type = p_type[7:0];
      r.msg_stream = p_msid;
      r.msg_time = p_time;
      r.msg_length = p_len[23:0];
    end
    r.last_of_message = last;
    if (cend && p_rcvd > p_window) begin
      r.ack_needed = 1'b1;
      r.ack_count = p_rcvd;
      p_rcvd = 0;
    end
    due_results.push_back(r);
  endfunction

  function automatic bit [31:0] eff_chunk(bit [31:0] c);
    return (c[30:0] == 0) ? 32'd1 : {1'b0, c[30:0]};
  endfunction

  function automatic void finish_header();
    bit [31:0] rem, cs;
    if (p_fmt == 0) begin
      sv_acc[p_slot] = 0;
    end else if (p_fmt == 3) begin
      p_time = sv_time[p_slot];
      p_len = sv_len[p_slot];
      p_type = sv_type[p_slot];
      p_msid = sv_msid[p_slot];
    end else begin
      p_time = p_time + sv_time[p_slot];
      p_msid = sv_msid[p_slot];
      if (p_fmt == 2) begin
        p_len = sv_len[p_slot];
        p_type = sv_type[p_slot];
      end
      sv_acc[p_slot] = 0;
    end
    sv_valid[p_slot] = 1'b1;
    sv_tag[p_slot] = p_cs;
    sv_time[p_slot] = p_time;
    sv_len[p_slot] = p_len;
    sv_type[p_slot] = p_type;
    sv_msid[p_slot] = p_msid;
    rem = (sv_acc[p_slot] < p_len) ? p_len - sv_acc[p_slot] : 0;
    cs = eff_chunk(p_chunk);
    p_left = (rem < cs) ? rem : cs;
    if (p_left == 0) begin
      sv_acc[p_slot] = 0;
      p_phase = PH_BASIC;
      emit(KIND_EMPTY, 8'd0, 1'b1, 1'b1);
    end else begin
      if (sv_acc[p_slot] == 0) p_ctl = 0;
      p_phase = PH_DATA;
    end
  endfunction

  function automatic void begin_header();
    int found, free_idx;
    found = STREAM_SLOTS;
    free_idx = STREAM_SLOTS;
    for (int i = 0; i < STREAM_SLOTS; i++) begin
      if (sv_valid[i]) begin
        if (sv_tag[i] == p_cs && found == STREAM_SLOTS) found = i;
      end else if (free_idx == STREAM_SLOTS) begin
        free_idx = i;
      end
    end
    if (found == STREAM_SLOTS && p_fmt != 0) begin
      p_phase = PH_BASIC;
      emit(KIND_NO_HEADER, 8'd0, 1'b0, 1'b0);
    end else if (found == STREAM_SLOTS && free_idx == STREAM_SLOTS) begin
      p_phase = PH_BASIC;
      emit(KIND_TABLE_FULL, 8'd0, 1'b0, 1'b0);
    end else begin
      p_slot = (found == STREAM_SLOTS) ? free_idx : found;
      p_time = 0;
      p_cnt = 0;
      if (p_fmt == 3) begin
        finish_header();
      end else begin
        if (p_fmt == 0) begin
          p_len = 0;
          p_type = 0;
          p_msid = 0;
        end else if (p_fmt == 1) begin
          p_len = 0;
          p_type = 0;
        end
        p_phase = PH_TS;
      end
    end
  endfunction

  function automatic void apply_control();
    if (p_len < 4) return;
    if (p_type == MSG_SET_CHUNK) begin
      p_chunk = {1'b0, p_ctl[30:0]};
    end else if (p_type == MSG_WINDOW) begin
      p_window = p_ctl;
    end else if (p_type == MSG_ABORT) begin
      for (int i = 0; i < STREAM_SLOTS; i++)
        if (sv_valid[i] && sv_tag[i] == p_ctl) sv_valid[i] = 1'b0;
    end
  endfunction

  function automatic void deframe_byte(bit [7:0] b);
    bit last, cend;
    p_rcvd = p_rcvd + 1;
    case (p_phase)
      PH_BASIC: begin
        p_fmt = b[7:6];
        p_cs = b[5:0];
        if (p_cs == 0) begin
          p_phase = PH_CS1;
        end else if (p_cs == 1) begin
          p_cnt = 0;
          p_cs = 0;
          p_phase = PH_CS2;
        end else begin
          begin_header();
        end
      end
      PH_CS1: begin
        p_cs = b + 64;
        begin_header();
      end
      PH_CS2: begin
        if (p_cnt == 0) begin
          p_cs = b;
          p_cnt = 1;
        end else begin
          p_cs = p_cs + (b << 8) + 64;
          begin_header();
        end
      end
      PH_TS: begin
        p_time = (p_time << 8) | b;
        p_cnt++;
        if (p_cnt == 3) begin
          p_cnt = 0;
          if (p_fmt == 2) begin
            if (p_time == TS_EXTENDED) begin
              p_time = 0;
              p_phase = PH_EXT;
            end else begin
              finish_header();
            end
          end else begin
            p_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        p_len = ((p_len << 8) | b) & 32'hFFFFFF;
        p_cnt++;
        if (p_cnt == 3) begin
          p_cnt = 0;
          p_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        p_type = b;
        if (p_fmt == 0) begin
          p_phase = PH_MSID;
        end else if (p_time == TS_EXTENDED) begin
          p_time = 0;
          p_phase = PH_EXT;
        end else begin
          finish_header();
        end
      end
      PH_MSID: begin
        p_msid = p_msid | (32'(b) << (8 * p_cnt[1:0]));
        p_cnt++;
        if (p_cnt == 4) begin
          p_cnt = 0;
          if (p_time == TS_EXTENDED) begin
            p_time = 0;
            p_phase = PH_EXT;
          end else begin
            finish_header();
          end
        end
      end
      PH_EXT: begin
        p_time = (p_time << 8) | b;
        p_cnt++;
        if (p_cnt == 4) begin
          p_cnt = 0;
          finish_header();
        end
      end
      PH_DATA: begin
        if (sv_acc[p_slot] < 4) p_ctl = (p_ctl << 8) | b;
        sv_acc[p_slot] = (sv_acc[p_slot] + 1) & 32'hFFFFFF;
        p_left--;
        last = sv_acc[p_slot] >= p_len;
        if (last) begin
          sv_acc[p_slot] = 0;
          apply_control();
        end
        cend = p_left == 0;
        if (cend) p_phase = PH_BASIC;
        emit(KIND_PAYLOAD, b, last, cend);
      end
      default: p_phase = PH_BASIC;
    endcase
  endfunction

  // stream generator with its own view of the table
  int        pool_cs [10] = '{2, 3, 63, 64, 65, 319, 320, 321, 65599, 40000};
  bit        g_valid [10];
  bit        g_partial [10];
  bit [31:0] g_len [10];
  bit [7:0]  g_type [10];
  int        g_used = 0;
  bit [31:0] g_chunk = RESET_CHUNK_SIZE;

  task automatic put_basic(bit [1:0] fmt, int cs);
    bit [15:0] v;
    v = 16'(cs - 64);
    if (cs < 64) begin
      rx_stream.push_back({fmt, 6'(cs)});
    end else if (cs < 320 && $urandom_range(0, 3) != 0) begin
      rx_stream.push_back({fmt, 6'd0});
      rx_stream.push_back(v[7:0]);
    end else begin
      rx_stream.push_back({fmt, 6'd1});
      rx_stream.push_back(v[7:0]);
      rx_stream.push_back(v[15:8]);
    end
  endtask

  function automatic bit [31:0] control_value_for(bit [7:0] typ);
    case (typ)
      MSG_SET_CHUNK: begin
        case ($urandom_range(0, 9))
          0: return 32'h0;
          1: return 32'h7FFFFFFF;
          2: return 32'h80000000 | $urandom_range(1, 9);
          3: return 32'hFFFFFFFF;
          default: return $urandom_range(1, 24);
        endcase
      end
      MSG_WINDOW: return ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(20, 400);
      default: return ($urandom_range(0, 3) == 0) ? $urandom() : pool_cs[$urandom_range(0, 9)];
    endcase
  endfunction

  task automatic send_message(int k, bit [1:0] fmt, bit [23:0] len, bit [7:0] typ,
                              bit trunc, bit ext);
    bit [7:0]  body[$];
    bit [31:0] val, n, sent, msid, ts;
    if (!g_valid[k] && (fmt != 0 || g_used == STREAM_SLOTS)) begin
      put_basic(fmt, pool_cs[k]);
      return;
    end
    if (g_partial[k] && fmt == 3) fmt = 2;
    put_basic(fmt, pool_cs[k]);
    if (fmt != 3) begin
      ts = ext ? 32'(TS_EXTENDED) : $urandom_range(0, 24'hFFFFFE);
      if (fmt != 0 && !ext && $urandom_range(0, 2) == 0) ts = $urandom_range(0, 40);
      rx_stream.push_back(ts[23:16]);
      rx_stream.push_back(ts[15:8]);
      rx_stream.push_back(ts[7:0]);
      if (fmt <= 1) begin
        rx_stream.push_back(len[23:16]);
        rx_stream.push_back(len[15:8]);
        rx_stream.push_back(len[7:0]);
        rx_stream.push_back(typ);
        g_len[k] = len;
        g_type[k] = typ;
      end
      if (fmt == 0) begin
        msid = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
        for (int i = 0; i < 4; i++) rx_stream.push_back(msid[8*i +: 8]);
      end
      if (ext) for (int i = 0; i < 4; i++) rx_stream.push_back(8'($urandom()));
    end
    if (!g_valid[k]) g_used++;
    g_valid[k] = 1'b1;
    g_partial[k] = 1'b0;
    len = g_len[k][23:0];
    typ = g_type[k];
    val = control_value_for(typ);
    // a truncated message only ever sends its first chunk
    for (int i = 0; i < len && (!trunc || i < g_chunk); i++)
      body.push_back((i < 4 && (typ == MSG_SET_CHUNK || typ == MSG_WINDOW || typ == MSG_ABORT))
                     ? val[31 - 8*i -: 8] : 8'($urandom()));
    sent = 0;
    while (sent < len) begin
      if (sent != 0) begin
        if (trunc) begin
          g_partial[k] = 1'b1;
          return;
        end
        put_basic(2'd3, pool_cs[k]);
      end
      n = (len - sent < g_chunk) ? len - sent : g_chunk;
      for (int i = 0; i < n; i++) rx_stream.push_back(body[sent + i]);
      sent += n;
    end
    if (len >= 4 && typ == MSG_SET_CHUNK) g_chunk = eff_chunk(val);
    if (len >= 4 && typ == MSG_ABORT)
      for (int i = 0; i < 10; i++)
        if (g_valid[i] && pool_cs[i] == val) begin
          g_valid[i] = 1'b0;
          g_used--;
        end
  endtask

  task automatic random_message();
    int        k;
    bit [1:0]  fmt;
    bit [23:0] len;
    bit [7:0]  typ;
    bit        trunc;
    if ($urandom_range(0, 24) == 0) begin
      rx_stream.push_back({2'($urandom_range(1, 3)), 6'($urandom_range(40, 62))});
      return;
    end
    k = $urandom_range(0, 9);
    if (!g_valid[k]) fmt = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
    else fmt = 2'($urandom_range(0, 3));
    if (g_valid[k] && g_len[k] > 1000 && fmt >= 2) fmt = 2'($urandom_range(0, 1));
    len = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(25, 200))
                                      : 24'($urandom_range(0, 24));
    case ($urandom_range(0, 19))
      0, 1: typ = MSG_SET_CHUNK;
      2: typ = MSG_WINDOW;
      3: typ = MSG_ABORT;
      4, 5, 6: typ = 8'($urandom());
      default: typ = 8'($urandom_range(8, 22));
    endcase
    if ((typ == MSG_SET_CHUNK || typ == MSG_WINDOW || typ == MSG_ABORT)
        && $urandom_range(0, 4) != 0)
      len = 24'($urandom_range(3, 6));
    trunc = $urandom_range(0, 11) == 0;
    if (trunc && g_chunk <= 64 && $urandom_range(0, 3) == 0)
      len = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF : 24'($urandom());
    send_message(k, fmt, len, typ, trunc, $urandom_range(0, 5) == 0);
  endtask

  // sender
  int tx_gap = 0;
  bit tx_burst = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) deframe_byte(in_byte);
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (rx_stream.size() > 0) begin
        in_byte <= rx_stream.pop_front();
        push <= 1'b1;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver
  int rx_gap = 0;
  bit rx_burst = 1'b0;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected transfer kind %h cs %h", $time, kind, chunk_stream);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("chunk_stream", want.chunk_stream, chunk_stream);
          check_field("msg_type", want.msg_type, msg_type);
          check_field("msg_stream", want.msg_stream, msg_stream);
          check_field("msg_time", want.msg_time, msg_time);
          check_field("msg_length", want.msg_length, msg_length);
          check_field("last_of_message", want.last_of_message, last_of_message);
          check_field("ack_needed", want.ack_needed, ack_needed);
          check_field("ack_count", want.ack_count, ack_count);
        end
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 7);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic drain();
    while (rx_stream.size() != 0 || push || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_CHUNK_SIZE) begin
      p_chunk = {1'b0, value[30:0]};
      g_chunk = eff_chunk(value);
    end else begin
      p_window = value;
    end
  endtask

  task automatic random_phase(int count);
    while (rx_stream.size() < count) random_message();
    drain();
  endtask

  initial begin
    parser_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // empty message, missing header, wide cs_id forms with extended time
    send_message(0, 2'd0, 24'd0, 8'd9, 1'b0, 1'b0);
    rx_stream.push_back({2'd3, 6'd50});
    send_message(8, 2'd0, 24'd2, 8'd8, 1'b0, 1'b1);
    send_message(8, 2'd1, 24'd1, 8'd255, 1'b0, 1'b1);
    send_message(4, 2'd0, 24'd0, 8'd0, 1'b0, 1'b0);
    send_message(4, 2'd3, 24'd0, 8'd0, 1'b0, 1'b0);
    drain();
    random_phase(380);
    write_reg(REG_CHUNK_SIZE, 32'd1);
    write_reg(REG_WINDOW_SIZE, 32'd1);
    random_phase(400);
    write_reg(REG_CHUNK_SIZE, 32'h7FFFFFFF);
    write_reg(REG_WINDOW_SIZE, 32'hFFFFFFFF);
    random_phase(400);
    write_reg(REG_CHUNK_SIZE, 32'd7);
    write_reg(REG_WINDOW_SIZE, 32'd300);
    random_phase(650);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS rtmp_chunk_deframer");
    end else begin
      $display("FAIL rtmp_chunk_deframer");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL rtmp_chunk_deframer");
    $finish;
  end

endmodule

/* files.f */
design/rcd_pkg.sv
design/rcd_front.sv
design/rcd_queue.sv
design/rtmp_chunk_deframer.sv
design/rcd_checker.sv
tb/tb_rtmp_chunk_deframer.sv
